@@ sv/fwr_fnv_pkg.sv @@
// shared types and constants of the firmware image receiver with fnv-1a check
package fwr_fnv_pkg;

    // function codes carried in the input tuser
    typedef enum logic [1:0] {
        FUNC_BEGIN  = 2'd0,
        FUNC_END    = 2'd1,
        FUNC_HEADER = 2'd2,
        FUNC_BYTE   = 2'd3
    } t_func;

    // reason codes of the response
    typedef enum logic [3:0] {
        RSN_NONE          = 4'd0,
        RSN_BAD_SCHEMA    = 4'd1,
        RSN_BAD_BEGIN     = 4'd2,
        RSN_INSTALL_UNAV  = 4'd3,
        RSN_NOT_ACTIVE    = 4'd4,
        RSN_OFFSET_MISM   = 4'd5,
        RSN_TOO_LARGE     = 4'd6,
        RSN_WRITE_FAILED  = 4'd7,
        RSN_VERIFY_FAILED = 4'd8
    } t_reason;

    localparam int unsigned MAX_CHUNK   = 256;
    localparam logic [7:0]  SCHEMA_ID   = 8'd1;
    localparam logic [31:0] FNV_PRIME   = 32'd16777619;
    localparam logic [31:0] FNV_BASIS   = 32'd2166136261;

    localparam int unsigned IN_DATA_W   = 160;
    localparam int unsigned OUT_DATA_W  = 40;

    // one input item after unpacking
    typedef struct packed {
        t_func       func;
        logic [7:0]  schema;
        logic        fields_ok;
        logic [31:0] seq;
        logic [31:0] size_value;
        logic [31:0] check_value;
        logic [31:0] offset;
        logic [8:0]  chunk_len;
        logic [7:0]  data_byte;
        logic        storage_ok;
    } t_in_item;

    // one response item
    typedef struct packed {
        logic        session_active;
        logic        storage_abort;
        logic        installed;
        logic [31:0] reply_seq;
        t_reason     reason;
        logic        nack;
    } t_out_item;

endpackage

@@ sv/firmware_image_receiver_fnv1a_unit.sv @@
// top level of the firmware image receiver with fnv-1a image check
//
// receiving side of a chunked firmware image transfer. every input transaction
// is one decoded item: begin session, end session, chunk header or chunk byte
// (kind in i_s_tuser). the block tracks the session, checks schema, offset and
// size, hashes chunk bytes with fnv-1a 32-bit into a pending chunk checksum and
// commits it only when the storage write reported on the last byte succeeded.
// begin, end and header items answer with one response transaction (ack or
// nack with a reason code, possibly a storage abort), but a header that opens
// a chunk is answered on its last byte; stray bytes are dropped silently.
// rate: one item per clock unless the input stage stalls. an item is held in
// the input register, and its response is written into the output register
// when the item is processed. the rate is set by the session state loop,
// whose longest path is one fnv-1a step (xor and multiply by the fnv prime
// constant) feeding the chunk checksum register.
// the input stage only stalls when a response is waiting in the output
// register and the downstream side is not ready.
module firmware_image_receiver_fnv1a_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // schema[7:0], fields_ok[8], seq[40:9], size_value[72:41],
    // check_value[104:73], offset[136:105], chunk_len[145:137],
    // data_byte[153:146], storage_ok[154], zero pad[159:155]
    input  logic [fwr_fnv_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // func[1:0]
    input  logic [1:0]  i_s_tuser,
    // response stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // nack[0], reason[4:1], reply_seq[36:5], installed[37],
    // storage_abort[38], session_active[39]
    output logic [fwr_fnv_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    // input register
    logic                  r_in_valid;
    fwr_fnv_pkg::t_in_item r_in;

    // response register
    logic                   r_out_valid;
    fwr_fnv_pkg::t_out_item r_out;

    // session state
    logic        r_active,         n_active;
    logic [31:0] r_expected_size,  n_expected_size;
    logic [31:0] r_expected_sum,   n_expected_sum;
    logic [31:0] r_received_count, n_received_count;
    logic [31:0] r_running_sum,    n_running_sum;
    logic [31:0] r_chunk_sum,      n_chunk_sum;
    logic        r_in_chunk,       n_in_chunk;
    logic [8:0]  r_bytes_left,     n_bytes_left;
    logic [8:0]  r_chunk_total,    n_chunk_total;
    logic [31:0] r_chunk_seq,      n_chunk_seq;

    // processing control
    logic                   w_advance;
    logic                   w_take;
    logic                   w_res_valid;
    fwr_fnv_pkg::t_out_item w_res;
    logic [31:0]            w_fnv;
    logic [32:0]            w_end_count;
    logic                   w_too_large;

    // the item in the input register is processed when the response register
    // is free or being drained in this cycle
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_take     = i_s_tvalid && o_s_tready;

    // one fnv-1a step on the pending chunk checksum
    assign w_fnv = (r_chunk_sum ^ {24'd0, r_in.data_byte}) * fwr_fnv_pkg::FNV_PRIME;

    // chunk would run past the announced image size or the chunk limit
    assign w_end_count = {1'b0, r_received_count} + {24'd0, r_in.chunk_len};
    assign w_too_large = ({23'd0, r_in.chunk_len} > 32'(fwr_fnv_pkg::MAX_CHUNK))
                      || (w_end_count > {1'b0, r_expected_size});

    always_comb begin
        n_active         = r_active;
        n_expected_size  = r_expected_size;
        n_expected_sum   = r_expected_sum;
        n_received_count = r_received_count;
        n_running_sum    = r_running_sum;
        n_chunk_sum      = r_chunk_sum;
        n_in_chunk       = r_in_chunk;
        n_bytes_left     = r_bytes_left;
        n_chunk_total    = r_chunk_total;
        n_chunk_seq      = r_chunk_seq;

        w_res_valid        = 1'b0;
        w_res.nack         = 1'b0;
        w_res.reason       = fwr_fnv_pkg::RSN_NONE;
        w_res.reply_seq    = r_in.seq;
        w_res.installed    = 1'b0;
        w_res.storage_abort = 1'b0;

        if (r_in.func == fwr_fnv_pkg::FUNC_BYTE) begin
            // chunk data byte, ignored outside a chunk
            if (r_in_chunk) begin
                n_chunk_sum  = w_fnv;
                n_bytes_left = r_bytes_left - 9'd1;
                if (n_bytes_left == 9'd0) begin
                    n_in_chunk      = 1'b0;
                    w_res_valid     = 1'b1;
                    w_res.reply_seq = r_chunk_seq;
                    if (!r_in.storage_ok) begin
                        n_active     = 1'b0;
                        w_res.nack   = 1'b1;
                        w_res.reason = fwr_fnv_pkg::RSN_WRITE_FAILED;
                    end else begin
                        // commit the chunk checksum and byte count
                        n_running_sum    = w_fnv;
                        n_received_count = r_received_count + {23'd0, r_chunk_total};
                    end
                end
            end
        end else begin
            // any message cancels a pending chunk
            n_in_chunk   = 1'b0;
            n_bytes_left = 9'd0;
            w_res_valid  = 1'b1;
            if (r_in.schema != fwr_fnv_pkg::SCHEMA_ID) begin
                w_res.nack   = 1'b1;
                w_res.reason = fwr_fnv_pkg::RSN_BAD_SCHEMA;
            end else if (r_in.func == fwr_fnv_pkg::FUNC_BEGIN) begin
                if (!r_in.fields_ok || r_in.size_value == 32'd0) begin
                    w_res.nack   = 1'b1;
                    w_res.reason = fwr_fnv_pkg::RSN_BAD_BEGIN;
                end else if (!r_in.storage_ok) begin
                    n_active     = 1'b0;
                    w_res.nack   = 1'b1;
                    w_res.reason = fwr_fnv_pkg::RSN_INSTALL_UNAV;
                end else begin
                    n_active         = 1'b1;
                    n_expected_size  = r_in.size_value;
                    n_expected_sum   = r_in.check_value;
                    n_received_count = 32'd0;
                    n_running_sum    = fwr_fnv_pkg::FNV_BASIS;
                end
            end else if (!r_active) begin
                w_res.nack   = 1'b1;
                w_res.reason = fwr_fnv_pkg::RSN_NOT_ACTIVE;
            end else if (r_in.func == fwr_fnv_pkg::FUNC_HEADER) begin
                if (!r_in.fields_ok || r_in.offset != r_received_count) begin
                    w_res.nack   = 1'b1;
                    w_res.reason = fwr_fnv_pkg::RSN_OFFSET_MISM;
                end else if (w_too_large) begin
                    n_active            = 1'b0;
                    w_res.nack          = 1'b1;
                    w_res.reason        = fwr_fnv_pkg::RSN_TOO_LARGE;
                    w_res.storage_abort = 1'b1;
                end else if (r_in.chunk_len != 9'd0) begin
                    // open the chunk, answered on its last byte
                    w_res_valid   = 1'b0;
                    n_in_chunk    = 1'b1;
                    n_bytes_left  = r_in.chunk_len;
                    n_chunk_total = r_in.chunk_len;
                    n_chunk_seq   = r_in.seq;
                    n_chunk_sum   = r_running_sum;
                end
            end else begin
                // end of session: verify size, both checksums and the storage result
                n_active = 1'b0;
                if (!r_in.fields_ok || r_in.size_value != r_received_count
                    || r_in.check_value != r_running_sum
                    || r_in.check_value != r_expected_sum || !r_in.storage_ok) begin
                    w_res.nack          = 1'b1;
                    w_res.reason        = fwr_fnv_pkg::RSN_VERIFY_FAILED;
                    w_res.storage_abort = 1'b1;
                end else begin
                    w_res.installed = 1'b1;
                end
            end
        end

        w_res.session_active = n_active;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.func        <= fwr_fnv_pkg::t_func'(i_s_tuser);
            r_in.schema      <= i_s_tdata[7:0];
            r_in.fields_ok   <= i_s_tdata[8];
            r_in.seq         <= i_s_tdata[40:9];
            r_in.size_value  <= i_s_tdata[72:41];
            r_in.check_value <= i_s_tdata[104:73];
            r_in.offset      <= i_s_tdata[136:105];
            r_in.chunk_len   <= i_s_tdata[145:137];
            r_in.data_byte   <= i_s_tdata[153:146];
            r_in.storage_ok  <= i_s_tdata[154];
        end
    end

    // session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active         <= 1'b0;
            r_expected_size  <= 32'd0;
            r_expected_sum   <= 32'd0;
            r_received_count <= 32'd0;
            r_running_sum    <= fwr_fnv_pkg::FNV_BASIS;
            r_chunk_sum      <= 32'd0;
            r_in_chunk       <= 1'b0;
            r_bytes_left     <= 9'd0;
            r_chunk_total    <= 9'd0;
            r_chunk_seq      <= 32'd0;
        end else if (w_advance) begin
            r_active         <= n_active;
            r_expected_size  <= n_expected_size;
            r_expected_sum   <= n_expected_sum;
            r_received_count <= n_received_count;
            r_running_sum    <= n_running_sum;
            r_chunk_sum      <= n_chunk_sum;
            r_in_chunk       <= n_in_chunk;
            r_bytes_left     <= n_bytes_left;
            r_chunk_total    <= n_chunk_total;
            r_chunk_seq      <= n_chunk_seq;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

@@ tb/firmware_image_receiver_fnv1a_unit_tb.sv @@
// testbench of the firmware image receiver with fnv-1a check: directed and random sessions
module firmware_image_receiver_fnv1a_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycle ceiling for the whole run, far above the slowest legal run
    localparam int RUN_LIMIT = 200000;
    // random stimulus stops once this many messages plus 30 are queued
    localparam int RANDOM_MSGS = 1500;

    // one queued message, optionally held back until every answer is in
    typedef struct packed {
        fwr_fnv_pkg::t_in_item msg;
        logic                  drain_first;
    } t_slot;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [fwr_fnv_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [1:0]                         i_s_tuser = '0;
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic [fwr_fnv_pkg::OUT_DATA_W-1:0] o_m_tdata;

    firmware_image_receiver_fnv1a_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // stimulus and scoreboard storage
    t_slot                  outgoing_msgs[$];
    fwr_fnv_pkg::t_out_item pending_answers[$];
    fwr_fnv_pkg::t_in_item  cur_msg;
    bit        offer_open = 1'b0;
    int        msgs_sent = 0;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        hold_left = 0;
    bit        long_hold_done = 1'b0;
    bit        quiet;

    // no random idling on either side within this window of transactions
    assign quiet = (msgs_sent >= 600) && (msgs_sent < 900);

    // predicted receiver state, starts at its reset values
    logic        sess_open = 1'b0;
    logic [31:0] want_size = '0;
    logic [31:0] want_sum = '0;
    logic [31:0] rx_count = '0;
    logic [31:0] image_sum = fwr_fnv_pkg::FNV_BASIS;
    logic [31:0] chunk_hash = '0;
    logic        chunk_open = 1'b0;
    logic [8:0]  chunk_remaining = '0;
    logic [8:0]  chunk_len_total = '0;
    logic [31:0] chunk_tag = '0;

    // one fnv-1a step: xor in the byte, then multiply by the prime mod 2^32
    function automatic logic [31:0] fnv_mix(logic [31:0] h, logic [7:0] b);
        return (h ^ {24'd0, b}) * fwr_fnv_pkg::FNV_PRIME;
    endfunction

    // tdata layout from bit 0 up: schema, fields_ok, seq, size, check, offset,
    // chunk_len, data_byte, storage_ok, zero pad
    function automatic logic [fwr_fnv_pkg::IN_DATA_W-1:0] pack_msg(fwr_fnv_pkg::t_in_item m);
        return {5'd0, m.storage_ok, m.data_byte, m.chunk_len, m.offset,
                m.check_value, m.size_value, m.seq, m.fields_ok, m.schema};
    endfunction

    function automatic fwr_fnv_pkg::t_out_item reply(logic nk, fwr_fnv_pkg::t_reason rs,
                                                     logic [31:0] sq, logic inst, logic ab);
        fwr_fnv_pkg::t_out_item r;
        r.nack           = nk;
        r.reason         = rs;
        r.reply_seq      = sq;
        r.installed      = inst;
        r.storage_abort  = ab;
        r.session_active = sess_open;
        return r;
    endfunction

    // advances the predicted state by one message and gives its answer, if any
    task automatic answer_for_msg(input fwr_fnv_pkg::t_in_item m, output bit has,
                                  output fwr_fnv_pkg::t_out_item a);
        has = 1'b1;
        a   = '0;
        if (m.func == fwr_fnv_pkg::FUNC_BYTE) begin
            // bytes only answer on the last byte of a pending chunk
            has = 1'b0;
            if (chunk_open) begin
                chunk_hash      = fnv_mix(chunk_hash, m.data_byte);
                chunk_remaining = chunk_remaining - 9'd1;
                if (chunk_remaining == 9'd0) begin
                    chunk_open = 1'b0;
                    has        = 1'b1;
                    if (!m.storage_ok) begin
                        sess_open = 1'b0;
                        a = reply(1'b1, fwr_fnv_pkg::RSN_WRITE_FAILED, chunk_tag, 1'b0, 1'b0);
                    end else begin
                        // write went through, commit the chunk checksum
                        image_sum = chunk_hash;
                        rx_count  = rx_count + {23'd0, chunk_len_total};
                        a = reply(1'b0, fwr_fnv_pkg::RSN_NONE, chunk_tag, 1'b0, 1'b0);
                    end
                end
            end
        end else begin
            // any framing message drops a pending chunk silently
            chunk_open      = 1'b0;
            chunk_remaining = '0;
            if (m.schema != fwr_fnv_pkg::SCHEMA_ID) begin
                a = reply(1'b1, fwr_fnv_pkg::RSN_BAD_SCHEMA, m.seq, 1'b0, 1'b0);
            end else if (m.func == fwr_fnv_pkg::FUNC_BEGIN) begin
                if (!m.fields_ok || m.size_value == 32'd0) begin
                    a = reply(1'b1, fwr_fnv_pkg::RSN_BAD_BEGIN, m.seq, 1'b0, 1'b0);
                end else if (!m.storage_ok) begin
                    sess_open = 1'b0;
                    a = reply(1'b1, fwr_fnv_pkg::RSN_INSTALL_UNAV, m.seq, 1'b0, 1'b0);
                end else begin
                    sess_open = 1'b1;
                    want_size = m.size_value;
                    want_sum  = m.check_value;
                    rx_count  = '0;
                    image_sum = fwr_fnv_pkg::FNV_BASIS;
                    a = reply(1'b0, fwr_fnv_pkg::RSN_NONE, m.seq, 1'b0, 1'b0);
                end
            end else if (!sess_open) begin
                a = reply(1'b1, fwr_fnv_pkg::RSN_NOT_ACTIVE, m.seq, 1'b0, 1'b0);
            end else if (m.func == fwr_fnv_pkg::FUNC_HEADER) begin
                if (!m.fields_ok || m.offset != rx_count) begin
                    a = reply(1'b1, fwr_fnv_pkg::RSN_OFFSET_MISM, m.seq, 1'b0, 1'b0);
                end else if (m.chunk_len > fwr_fnv_pkg::MAX_CHUNK ||
                             {1'b0, rx_count} + m.chunk_len > {1'b0, want_size}) begin
                    sess_open = 1'b0;
                    a = reply(1'b1, fwr_fnv_pkg::RSN_TOO_LARGE, m.seq, 1'b0, 1'b1);
                end else if (m.chunk_len == 9'd0) begin
                    // empty chunk is acknowledged at once
                    a = reply(1'b0, fwr_fnv_pkg::RSN_NONE, m.seq, 1'b0, 1'b0);
                end else begin
                    chunk_open      = 1'b1;
                    chunk_remaining = m.chunk_len;
                    chunk_len_total = m.chunk_len;
                    chunk_tag       = m.seq;
                    chunk_hash      = image_sum;
                    has             = 1'b0;
                end
            end else begin
                // end of session: size, both checksums and install result
                sess_open = 1'b0;
                if (!m.fields_ok || m.size_value != rx_count || m.check_value != image_sum ||
                    m.check_value != want_sum || !m.storage_ok)
                    a = reply(1'b1, fwr_fnv_pkg::RSN_VERIFY_FAILED, m.seq, 1'b0, 1'b1);
                else
                    a = reply(1'b0, fwr_fnv_pkg::RSN_NONE, m.seq, 1'b1, 1'b0);
            end
        end
    endtask

    // every field random, so unused fields toggle too
    function automatic fwr_fnv_pkg::t_in_item rand_msg();
        fwr_fnv_pkg::t_in_item m;
        m.func        = fwr_fnv_pkg::t_func'($urandom_range(3));
        m.schema      = 8'($urandom_range(255));
        m.fields_ok   = 1'($urandom_range(1));
        m.seq         = $urandom();
        m.size_value  = $urandom();
        m.check_value = $urandom();
        m.offset      = $urandom();
        m.chunk_len   = 9'($urandom_range(511));
        m.data_byte   = 8'($urandom_range(255));
        m.storage_ok  = 1'($urandom_range(1));
        return m;
    endfunction

    // well-formed message with random filler in the fields it does not use
    function automatic fwr_fnv_pkg::t_in_item mk(fwr_fnv_pkg::t_func f, logic fok,
                                                 logic [31:0] sz, logic [31:0] ck,
                                                 logic [31:0] offs, logic [8:0] clen,
                                                 logic [7:0] b, logic sok);
        fwr_fnv_pkg::t_in_item m;
        m = rand_msg();
        m.func      = f;
        m.schema    = fwr_fnv_pkg::SCHEMA_ID;
        m.fields_ok = fok;
        m.storage_ok = sok;
        if (f == fwr_fnv_pkg::FUNC_BEGIN || f == fwr_fnv_pkg::FUNC_END) begin
            m.size_value  = sz;
            m.check_value = ck;
        end
        if (f == fwr_fnv_pkg::FUNC_HEADER) begin
            m.offset    = offs;
            m.chunk_len = clen;
        end
        if (f == fwr_fnv_pkg::FUNC_BYTE)
            m.data_byte = b;
        return m;
    endfunction

    task automatic queue_msg(fwr_fnv_pkg::t_in_item m, logic drain);
        t_slot s;
        s.msg         = m;
        s.drain_first = drain;
        outgoing_msgs.push_back(s);
    endtask

    // full transfer: begin, chunks with their bytes, end with the right size and
    // checksum; optionally damaged by dropping, inserting or scrambling messages
    task automatic build_session(int n_chunks, bit mutate, bit drain_first);
        fwr_fnv_pkg::t_in_item sess[$];
        logic [7:0]  img[$];
        int          lens[$];
        logic [31:0] h;
        int          total;
        int          pos;
        int          len;
        int          idx;
        fwr_fnv_pkg::t_in_item m;
        total = 0;
        h     = fwr_fnv_pkg::FNV_BASIS;
        for (int c = 0; c < n_chunks; c++) begin
            if ($urandom_range(99) < 4)
                len = $urandom_range(1) ? fwr_fnv_pkg::MAX_CHUNK
                                        : $urandom_range(200, fwr_fnv_pkg::MAX_CHUNK - 1);
            else
                len = $urandom_range(1, 12);
            lens.push_back(len);
            total += len;
        end
        for (int i = 0; i < total; i++) begin
            img.push_back(8'($urandom_range(255)));
            h = fnv_mix(h, img[i]);
        end
        sess.push_back(mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, total, h, '0, '0, '0, 1'b1));
        pos = 0;
        for (int c = 0; c < n_chunks; c++) begin
            sess.push_back(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, pos, 9'(lens[c]),
                              '0, 1'b1));
            for (int j = 0; j < lens[c]; j++) begin
                // only the last byte's storage flag matters
                m = mk(fwr_fnv_pkg::FUNC_BYTE, 1'($urandom_range(1)), '0, '0, '0, '0,
                       img[pos + j],
                       (j == lens[c] - 1) ? 1'b1 : 1'($urandom_range(1)));
                sess.push_back(m);
            end
            pos += lens[c];
        end
        sess.push_back(mk(fwr_fnv_pkg::FUNC_END, 1'b1, total, h, '0, '0, '0, 1'b1));
        if (mutate && $urandom_range(99) < 30) begin
            idx = $urandom_range(sess.size() - 1);
            case ($urandom_range(4))
                0: sess.delete(idx);
                1: begin
                    m = rand_msg();
                    m.func = sess[idx].func;
                    sess[idx] = m;
                end
                2: sess[idx].storage_ok = ~sess[idx].storage_ok;
                3: sess[idx].schema = 8'($urandom_range(255));
                default: sess.insert(idx, rand_msg());
            endcase
        end
        for (int i = 0; i < sess.size(); i++)
            queue_msg(sess[i], drain_first && i == 0);
    endtask

    // sender: offers the next queued message at the falling edge, holds it until taken
    always @(negedge i_clk) begin
        if (i_rst_n && !offer_open) begin
            if (outgoing_msgs.size() > 0 &&
                !(outgoing_msgs[0].drain_first && pending_answers.size() > 0) &&
                (quiet || $urandom_range(99) >= 15)) begin
                cur_msg    = outgoing_msgs[0].msg;
                void'(outgoing_msgs.pop_front());
                offer_open = 1'b1;
                i_s_tdata  <= pack_msg(cur_msg);
                i_s_tuser  <= cur_msg.func;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off so the block backs up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!long_hold_done && msgs_sent >= 250) begin
                hold_left      = 400;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= quiet || ($urandom_range(99) >= 15);
            end
        end
    end

    // monitor: checks each response transaction, then predicts for each accepted message
    always @(posedge i_clk) begin : monitor
        fwr_fnv_pkg::t_out_item got;
        fwr_fnv_pkg::t_out_item want;
        fwr_fnv_pkg::t_out_item ans;
        bit        has;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata;
                if (pending_answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response transaction: tdata %h", o_m_tdata);
                end else begin
                    want = pending_answers.pop_front();
                    if (got.nack !== want.nack || got.reason !== want.reason ||
                        got.reply_seq !== want.reply_seq || got.installed !== want.installed ||
                        got.storage_abort !== want.storage_abort ||
                        got.session_active !== want.session_active) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"response mismatch: expected nack %0d reason %0d seq %h ",
                                      "inst %0d abort %0d active %0d, got nack %0d reason %0d ",
                                      "seq %h inst %0d abort %0d active %0d"},
                                     want.nack, want.reason, want.reply_seq, want.installed,
                                     want.storage_abort, want.session_active,
                                     got.nack, got.reason, got.reply_seq, got.installed,
                                     got.storage_abort, got.session_active);
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                answer_for_msg(cur_msg, has, ans);
                if (has)
                    pending_answers.push_back(ans);
                msgs_sent++;
                offer_open = 1'b0;
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        fwr_fnv_pkg::t_in_item m;
        bit       mid_drain_done;
        mid_drain_done = 1'b0;

        // directed: every reason code and each corner case
        // end, no session
        queue_msg(mk(fwr_fnv_pkg::FUNC_END, 1'b1, '0, '0, '0, '0, '0, 1'b1), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, '0, 9'd4, '0, 1'b1), 1'b0);
        // stray byte
        queue_msg(mk(fwr_fnv_pkg::FUNC_BYTE, 1'b1, '0, '0, '0, '0, 8'hA5, 1'b1), 1'b0);
        m = mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, 32'd10, '0, '0, '0, '0, 1'b1);
        m.schema = 8'h00;
        queue_msg(m, 1'b0);
        m.schema = 8'hFF;
        queue_msg(m, 1'b0);
        // fields missing
        queue_msg(mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b0, 32'd10, '0, '0, '0, '0, 1'b1), 1'b0);
        // zero size
        queue_msg(mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, 32'd0, '0, '0, '0, '0, 1'b1), 1'b0);
        // install fails
        queue_msg(mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, 32'd10, '0, '0, '0, '0, 1'b0), 1'b0);
        m = mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, 1'b1);
        m.seq = 32'hFFFF_FFFF;
        queue_msg(m, 1'b0);
        // bad offset
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, 32'd5, 9'd3, '0, 1'b1), 1'b0);
        // fields missing
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b0, '0, '0, 32'd0, 9'd3, '0, 1'b1), 1'b0);
        // empty chunk
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, 32'd0, 9'd0, '0, 1'b1), 1'b0);
        // over max
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, 32'd0, 9'd511, '0, 1'b1), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, 32'd4, '0, '0, '0, '0, 1'b1), 1'b0);
        // past size
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, 32'd0, 9'd5, '0, 1'b1), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, 32'd3, '0, '0, '0, '0, 1'b1), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, 32'd0, 9'd3, '0, 1'b1), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_BYTE, 1'b1, '0, '0, '0, '0, 8'h00, 1'b1), 1'b0);
        // a new header cancels the chunk above without an answer
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, 32'd0, 9'd2, '0, 1'b1), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_BYTE, 1'b1, '0, '0, '0, '0, 8'hFF, 1'b1), 1'b0);
        // write fails
        queue_msg(mk(fwr_fnv_pkg::FUNC_BYTE, 1'b1, '0, '0, '0, '0, 8'h5A, 1'b0), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_BEGIN, 1'b1, 32'd1, $urandom(), '0, '0, '0, 1'b1),
                  1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_HEADER, 1'b1, '0, '0, 32'd0, 9'd1, '0, 1'b1), 1'b0);
        queue_msg(mk(fwr_fnv_pkg::FUNC_BYTE, 1'b1, '0, '0, '0, '0, 8'h3C, 1'b1), 1'b0);
        // verify fails
        queue_msg(mk(fwr_fnv_pkg::FUNC_END, 1'b0, 32'd1, '0, '0, '0, '0, 1'b1), 1'b0);
        build_session(2, 1'b0, 1'b0);                                      // clean install

        // random: mostly well-formed sessions with random damage, some noise
        while (outgoing_msgs.size() < RANDOM_MSGS + 30) begin
            if ($urandom_range(99) < 10) begin
                queue_msg(rand_msg(), 1'b0);
            end else begin
                // the first random session and one mid-run wait for all answers first
                build_session($urandom_range(1, 4), 1'b1,
                              outgoing_msgs.size() < 40 ||
                              (!mid_drain_done && outgoing_msgs.size() > 1000));
                if (outgoing_msgs.size() > 1000)
                    mid_drain_done = 1'b1;
            end
        end

        // single reset at the start
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all stimulus to be taken and all answers to arrive
        while (outgoing_msgs.size() > 0 || offer_open)
            @(posedge i_clk);
        while (pending_answers.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending_answers.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
